// ===== src/ffmd_pkg.sv =====
package ffmd_pkg;

    localparam logic [7:0] SYNC_ONE = 8'hB5;
    localparam logic [7:0] SYNC_TWO = 8'h62;

    localparam logic [7:0]  RST_CLASS  = 8'h01;
    localparam logic [7:0]  RST_ID     = 8'h61;
    localparam logic [15:0] RST_LENGTH = 16'd4;

    localparam int CFG_DATA_W = 16;

    typedef enum logic [1:0] {
        CFG_IDX_CLASS  = 2'd0,
        CFG_IDX_ID     = 2'd1,
        CFG_IDX_LENGTH = 2'd2
    } t_cfg_idx;

    typedef enum logic [3:0] {
        PH_HUNT    = 4'd0,
        PH_SYNC2   = 4'd1,
        PH_CLASS   = 4'd2,
        PH_ID      = 4'd3,
        PH_LEN_LO  = 4'd4,
        PH_LEN_HI  = 4'd5,
        PH_PAYLOAD = 4'd6,
        PH_CK_A    = 4'd7,
        PH_CK_B    = 4'd8
    } t_phase;

    typedef struct packed {
        logic [7:0]  exp_class;
        logic [7:0]  exp_id;
        logic [15:0] exp_length;
    } t_cfg;

endpackage

// ===== src/ffmd_cfg_regs.sv =====
module ffmd_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [1:0]                      i_cfg_index,
    input  logic [ffmd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output ffmd_pkg::t_cfg                  o_cfg
);

    ffmd_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.exp_class  <= ffmd_pkg::RST_CLASS;
            r_cfg.exp_id     <= ffmd_pkg::RST_ID;
            r_cfg.exp_length <= ffmd_pkg::RST_LENGTH;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ffmd_pkg::CFG_IDX_CLASS:  r_cfg.exp_class  <= i_cfg_data[7:0];
                ffmd_pkg::CFG_IDX_ID:     r_cfg.exp_id     <= i_cfg_data[7:0];
                ffmd_pkg::CFG_IDX_LENGTH: r_cfg.exp_length <= i_cfg_data[15:0];
                default: begin
                    // drop writes to unmapped indexes
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== src/ffmd_parser.sv =====
module ffmd_parser (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_step,
    input  logic [7:0]     i_byte,
    input  ffmd_pkg::t_cfg i_cfg,
    output logic           o_frame_valid
);

    ffmd_pkg::t_phase r_phase, n_phase;
    logic [7:0]       r_sum_a, n_sum_a;
    logic [7:0]       r_sum_b, n_sum_b;
    logic [15:0]      r_left, n_left;

    logic [7:0]  w_add_a;
    logic [7:0]  w_add_b;
    logic [15:0] w_left_dec;
    logic        w_hdr_ok;

    assign w_add_a    = r_sum_a + i_byte;
    assign w_add_b    = r_sum_b + w_add_a;
    assign w_left_dec = (r_left != 16'd0) ? (r_left - 16'd1) : 16'd0;

    // header byte matches what the current phase wants
    always_comb begin
        case (r_phase)
            ffmd_pkg::PH_CLASS:  w_hdr_ok = (i_byte == i_cfg.exp_class);
            ffmd_pkg::PH_ID:     w_hdr_ok = (i_byte == i_cfg.exp_id);
            ffmd_pkg::PH_LEN_LO: w_hdr_ok = (i_byte == i_cfg.exp_length[7:0]);
            ffmd_pkg::PH_LEN_HI: w_hdr_ok = (i_byte == i_cfg.exp_length[15:8]);
            default:             w_hdr_ok = 1'b0;
        endcase
    end

    // next phase
    always_comb begin
        case (r_phase)
            ffmd_pkg::PH_HUNT:
                n_phase = (i_byte == ffmd_pkg::SYNC_ONE) ? ffmd_pkg::PH_SYNC2
                                                         : ffmd_pkg::PH_HUNT;
            ffmd_pkg::PH_SYNC2: begin
                if (i_byte == ffmd_pkg::SYNC_TWO) begin
                    n_phase = ffmd_pkg::PH_CLASS;
                end else if (i_byte == ffmd_pkg::SYNC_ONE) begin
                    n_phase = ffmd_pkg::PH_SYNC2;
                end else begin
                    n_phase = ffmd_pkg::PH_HUNT;
                end
            end
            ffmd_pkg::PH_CLASS:
                n_phase = w_hdr_ok ? ffmd_pkg::PH_ID : ffmd_pkg::PH_HUNT;
            ffmd_pkg::PH_ID:
                n_phase = w_hdr_ok ? ffmd_pkg::PH_LEN_LO : ffmd_pkg::PH_HUNT;
            ffmd_pkg::PH_LEN_LO:
                n_phase = w_hdr_ok ? ffmd_pkg::PH_LEN_HI : ffmd_pkg::PH_HUNT;
            ffmd_pkg::PH_LEN_HI: begin
                if (!w_hdr_ok) begin
                    n_phase = ffmd_pkg::PH_HUNT;
                end else if (i_cfg.exp_length == 16'd0) begin
                    n_phase = ffmd_pkg::PH_CK_A;
                end else begin
                    n_phase = ffmd_pkg::PH_PAYLOAD;
                end
            end
            ffmd_pkg::PH_PAYLOAD:
                n_phase = (w_left_dec == 16'd0) ? ffmd_pkg::PH_CK_A
                                                : ffmd_pkg::PH_PAYLOAD;
            ffmd_pkg::PH_CK_A:
                n_phase = (i_byte == r_sum_a) ? ffmd_pkg::PH_CK_B : ffmd_pkg::PH_HUNT;
            default:
                n_phase = ffmd_pkg::PH_HUNT;
        endcase
    end

    // checksum, payload count and result flag
    always_comb begin
        n_sum_a       = r_sum_a;
        n_sum_b       = r_sum_b;
        n_left        = r_left;
        o_frame_valid = 1'b0;
        case (r_phase)
            ffmd_pkg::PH_HUNT: begin
            end
            ffmd_pkg::PH_SYNC2: begin
                if (i_byte == ffmd_pkg::SYNC_TWO) begin
                    n_sum_a = 8'd0;
                    n_sum_b = 8'd0;
                end
            end
            ffmd_pkg::PH_CLASS, ffmd_pkg::PH_ID, ffmd_pkg::PH_LEN_LO: begin
                if (w_hdr_ok) begin
                    n_sum_a = w_add_a;
                    n_sum_b = w_add_b;
                end else begin
                    n_sum_a = 8'd0;
                    n_sum_b = 8'd0;
                    n_left  = 16'd0;
                end
            end
            ffmd_pkg::PH_LEN_HI: begin
                if (w_hdr_ok) begin
                    n_sum_a = w_add_a;
                    n_sum_b = w_add_b;
                    n_left  = i_cfg.exp_length;
                end else begin
                    n_sum_a = 8'd0;
                    n_sum_b = 8'd0;
                    n_left  = 16'd0;
                end
            end
            ffmd_pkg::PH_PAYLOAD: begin
                n_sum_a = w_add_a;
                n_sum_b = w_add_b;
                n_left  = w_left_dec;
            end
            ffmd_pkg::PH_CK_A: begin
                if (i_byte != r_sum_a) begin
                    n_sum_a = 8'd0;
                    n_sum_b = 8'd0;
                    n_left  = 16'd0;
                end
            end
            ffmd_pkg::PH_CK_B: begin
                o_frame_valid = (i_byte == r_sum_b);
                n_sum_a       = 8'd0;
                n_sum_b       = 8'd0;
                n_left        = 16'd0;
            end
            default: begin
                n_sum_a = 8'd0;
                n_sum_b = 8'd0;
                n_left  = 16'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= ffmd_pkg::PH_HUNT;
            r_sum_a <= 8'd0;
            r_sum_b <= 8'd0;
            r_left  <= 16'd0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_sum_a <= n_sum_a;
            r_sum_b <= n_sum_b;
            r_left  <= n_left;
        end
    end

endmodule

// ===== src/fixed_frame_marker_detector.sv =====
// A beat accepted on the slave side passes through the input register, then the result
// register, before its result appears on the master side.
// Throughput: one byte per cycle while the master side takes results; a held result stalls the input.
// Reset (i_rst_n low, synchronous): parser returns to sync hunt with sums and count
// cleared, both registers empty, configuration back to class 0x01, id 0x61, length 4.
module fixed_frame_marker_detector (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [0] frame_valid, [7:1] zero
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [ffmd_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    ffmd_pkg::t_cfg w_cfg;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    logic       r_out_flag;

    logic w_slot_free;
    logic w_step;
    logic w_flag;

    assign w_slot_free   = !r_out_valid || m_axis_tready;
    assign w_step        = r_in_valid && w_slot_free;
    assign s_axis_tready = !r_in_valid || w_slot_free;

    ffmd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    ffmd_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (w_step),
        .i_byte        (r_in_byte),
        .i_cfg         (w_cfg),
        .o_frame_valid (w_flag)
    );

    // input register: take a new beat when empty or whenever the held one moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    // result register: hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_slot_free) begin
            r_out_valid <= w_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_flag <= w_flag;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out_flag};

endmodule
